[design/spmq_pkg.sv]
package spmq_pkg;

    // default build of the block
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int NUM_LEVELS_DEF  = 3;

    // fixed widths of the word fields
    localparam int CMD_W    = 1;
    localparam int MSG_W    = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PRIO = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } t_state;

endpackage

[design/spmq_if.sv]
interface spmq_in_if;
    logic                          valid;
    logic                          ready;
    logic [spmq_pkg::CMD_W-1:0]    cmd;
    logic [spmq_pkg::MSG_W-1:0]    msg_handle;
    logic [spmq_pkg::PRIO_W-1:0]   prio_level;

    modport source (output valid, cmd, msg_handle, prio_level, input ready);
    modport sink   (input valid, cmd, msg_handle, prio_level, output ready);
endinterface

interface spmq_out_if #(
    parameter int HANDLE_BITS = spmq_pkg::HANDLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [spmq_pkg::STATUS_W-1:0]   status;
    logic                            out_valid;
    logic [HANDLE_BITS-1:0]          out_handle;

    modport source (output valid, status, out_valid, out_handle, input ready);
    modport sink   (input valid, status, out_valid, out_handle, output ready);
endinterface

[design/spmq_ctrl.sv]
module spmq_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_accept
);

    spmq_pkg::t_state r_state;
    spmq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spmq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = spmq_pkg::S_OUT;
                end
            end
            spmq_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = spmq_pkg::S_IDLE;
                end
            end
            default: n_state = spmq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_accept    = 1'b0;
        unique case (r_state)
            spmq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_accept   = i_in_valid;
            end
            spmq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/spmq_dpath.sv]
module spmq_dpath #(
    parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = spmq_pkg::HANDLE_BITS_DEF,
    parameter int NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [spmq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [spmq_pkg::MSG_W-1:0]      i_msg_handle,
    input  logic [spmq_pkg::PRIO_W-1:0]     i_prio_level,
    output logic [spmq_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_out_valid,
    output logic [HANDLE_BITS-1:0]          o_out_handle
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    logic [PTR_W-1:0]       r_rd_ptr [NUM_LEVELS];
    logic [PTR_W-1:0]       r_wr_ptr [NUM_LEVELS];
    logic [CNT_W-1:0]       r_cnt    [NUM_LEVELS];
    logic [HANDLE_BITS-1:0] r_mem    [ENTRIES];
    logic [HANDLE_BITS-1:0] r_rd_data;
    spmq_pkg::t_status      r_status;
    logic                   r_res_valid;

    logic [spmq_pkg::PRIO_W-1:0] w_lvl_m1;
    logic [LVL_W-1:0]            w_push_q;
    logic                        w_prio_ok;
    logic                        w_full;
    logic [LVL_W-1:0]            w_pop_q;
    logic                        w_any;
    logic                        w_is_pop;
    logic                        w_do_push;
    logic                        w_do_pop;
    logic [ADDR_W-1:0]           w_waddr;
    logic [ADDR_W-1:0]           w_raddr;
    spmq_pkg::t_status           w_status;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // push side decode
    assign w_lvl_m1  = i_prio_level - spmq_pkg::PRIO_W'(1);
    assign w_push_q  = w_lvl_m1[LVL_W-1:0];
    assign w_prio_ok = (i_prio_level != '0) && (int'(i_prio_level) <= NUM_LEVELS);
    assign w_full    = (r_cnt[w_push_q] == CNT_W'(QUEUE_DEPTH));
    assign w_is_pop  = (i_cmd == spmq_pkg::CMD_POP);

    // pop side: lowest-numbered non-empty level wins
    always_comb begin
        w_pop_q = '0;
        w_any   = 1'b0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[l] != '0) begin
                w_pop_q = LVL_W'(l);
                w_any   = 1'b1;
            end
        end
    end

    always_comb begin
        if (w_is_pop) begin
            w_status = w_any ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
        end else if (!w_prio_ok) begin
            w_status = spmq_pkg::ST_BAD_PRIO;
        end else if (w_full) begin
            w_status = spmq_pkg::ST_FULL;
        end else begin
            w_status = spmq_pkg::ST_OK;
        end
    end

    assign w_do_push = i_accept && !w_is_pop && w_prio_ok && !w_full;
    assign w_do_pop  = i_accept && w_is_pop && w_any;

    assign w_waddr = ADDR_W'(w_push_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_wr_ptr[w_push_q]);
    assign w_raddr = ADDR_W'(w_pop_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_rd_ptr[w_pop_q]);

    // handle store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[w_waddr] <= HANDLE_BITS'(i_msg_handle);
        end
        if (w_do_pop) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // pointers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_rd_ptr[l] <= '0;
                r_wr_ptr[l] <= '0;
                r_cnt[l]    <= '0;
            end
        end else begin
            if (w_do_push) begin
                r_wr_ptr[w_push_q] <= wrap_inc(r_wr_ptr[w_push_q]);
                r_cnt[w_push_q]    <= r_cnt[w_push_q] + CNT_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr[w_pop_q] <= wrap_inc(r_rd_ptr[w_pop_q]);
                r_cnt[w_pop_q]    <= r_cnt[w_pop_q] - CNT_W'(1);
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status    <= w_status;
            r_res_valid <= w_do_pop;
        end
    end

    assign o_status     = r_status;
    assign o_out_valid  = r_res_valid;
    assign o_out_handle = r_res_valid ? r_rd_data : '0;

endmodule

[design/strict_priority_multi_queue.sv]
// strict-priority queue of message handles with NUM_LEVELS fifo levels of
// QUEUE_DEPTH entries each. a push word (cmd 0) appends msg_handle to the
// queue of prio_level 1..NUM_LEVELS; any other level gives status 1 and a
// push to a full level gives status 2, both leaving the queues untouched.
// a pop word (cmd 1) returns the head of the lowest-numbered non-empty level
// with out_valid set, or status 3 with no handle when every level is empty.
// every input word yields exactly one result word. one word is in flight at
// a time: the result appears the cycle after acceptance and the next input
// word is taken the cycle after the result is taken. the pacing is set by
// the single shared handle memory with its registered read port and the
// two-state sequencer around it. no clearing pass is needed after reset.
module strict_priority_multi_queue #(
    parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = spmq_pkg::HANDLE_BITS_DEF,
    parameter int NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spmq_in_if.sink       i_in,
    spmq_out_if.source    o_out
);

    // handshake sequencing lives in the controller
    logic w_accept;

    spmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_accept    (w_accept)
    );

    // queues, pointers and the result word register
    spmq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (i_in.cmd),
        .i_msg_handle (i_in.msg_handle),
        .i_prio_level (i_in.prio_level),
        .o_status     (o_out.status),
        .o_out_valid  (o_out.out_valid),
        .o_out_handle (o_out.out_handle)
    );

endmodule
